@@ sv/tdpl_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpl_pkg
// Shared types and constants for the prime list generator and its sieve cells.
// ----------------------------------------------------------------------------
package tdpl_pkg;

    // Upper bound on primes per run; also the number of sieve cells
    localparam int MAX_COUNT   = 64;
    // Width to which each emitted prime is masked
    localparam int VALUE_WIDTH = 9;
    // Field widths of the ports
    localparam int COUNT_W     = 7;
    localparam int PRIME_W     = 9;
    // Candidate / multiple width: the 64th prime is 311, multiples stay at or below 2*311
    localparam int CAND_W      = 10;

    localparam logic [PRIME_W-1:0] VALUE_MASK =
        PRIME_W'((64'd1 << VALUE_WIDTH) - 64'd1);

    // Candidate word moving down the chain
    typedef struct packed {
        logic              valid;
        logic              marked;   // a cell upstream found it composite
        logic [CAND_W-1:0] cand;
    } t_slot;

    // Prime found by a cell, registered on capture
    typedef struct packed {
        logic              valid;
        logic [CAND_W-1:0] value;
    } t_emit;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

@@ sv/tdpl_cell.sv @@
// ----------------------------------------------------------------------------
// tdpl_cell
// One sieve cell: holds one prime and its next multiple, marks candidates
// equal to that multiple, or captures the first unmarked candidate when empty.
// ----------------------------------------------------------------------------
module tdpl_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  tdpl_pkg::t_slot i_slot,
    output tdpl_pkg::t_slot o_slot,
    output tdpl_pkg::t_emit o_emit
);
    import tdpl_pkg::*;

    logic              r_used;
    logic [CAND_W-1:0] r_prime;
    logic [CAND_W-1:0] r_mult;
    t_slot             r_slot;
    t_emit             r_emit;

    logic              hit;
    logic              capture;
    t_slot             n_slot;

    // Compare against the running multiple, or take the candidate as a new prime
    always_comb begin
        hit     = r_used && i_slot.valid && (i_slot.cand == r_mult);
        capture = !r_used && i_slot.valid && !i_slot.marked;
        n_slot        = i_slot;
        n_slot.marked = i_slot.marked | hit;
        n_slot.valid  = i_slot.valid & ~capture;
    end

    // Control state and payload; only the valid bits and the used flag clear
    always_ff @(posedge i_clk) begin
        r_slot.marked <= n_slot.marked;
        r_slot.cand   <= n_slot.cand;
        r_emit.value  <= i_slot.cand;
        if (!i_rst_n || i_clear) begin
            r_used       <= 1'b0;
            r_slot.valid <= 1'b0;
            r_emit.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
            r_emit.valid <= capture;
            if (capture) begin
                r_used <= 1'b1;
            end
        end
        if (capture) begin
            r_prime <= i_slot.cand;
            r_mult  <= i_slot.cand + i_slot.cand;
        end else if (hit) begin
            r_mult  <= r_mult + r_prime;
        end
    end

    assign o_slot = r_slot;
    assign o_emit = r_emit;

endmodule

@@ sv/trial_division_prime_list.sv @@
// Sequence: candidates from 2 upward enter the chain once a request is taken; each
//   prime passes the cell's emit register, then the output register.
// Throughput: one request at a time; busy stays high for the whole run, set by
//   candidates stepping one per cycle through a chain of 64 sieve cells.
// Reset: synchronous, active low; clears all cells and returns to idle.
// Results are strobed for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
// trial_division_prime_list
// Emits the first N primes in ascending order from a systolic sieve chain.
// ----------------------------------------------------------------------------
module trial_division_prime_list (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tdpl_pkg::COUNT_W-1:0] i_prime_count,
    output logic                         o_strobe,
    output logic [tdpl_pkg::PRIME_W-1:0] o_prime_value,
    output logic                         o_last_in_run
);
    import tdpl_pkg::*;

    t_state             r_state;
    logic [COUNT_W-1:0] r_want;
    logic [COUNT_W-1:0] r_have;
    logic [CAND_W-1:0]  r_cand;
    logic               r_strobe;
    logic [PRIME_W-1:0] r_value;
    logic               r_last;

    t_slot              slots [MAX_COUNT+1];
    t_emit              emits [MAX_COUNT];
    t_emit              found;
    logic               accept;
    logic               is_last;
    logic               clear;
    logic [COUNT_W-1:0] n_want;

    assign accept = start && (r_state == ST_IDLE);

    // Saturate the request to 1..MAX_COUNT
    always_comb begin
        if (i_prime_count > COUNT_W'(MAX_COUNT)) begin
            n_want = COUNT_W'(MAX_COUNT);
        end else if (i_prime_count == '0) begin
            n_want = COUNT_W'(1);
        end else begin
            n_want = i_prime_count;
        end
    end

    // Candidate feed into the head of the chain
    assign slots[0] = '{valid: (r_state == ST_RUN), marked: 1'b0, cand: r_cand};

    // Sieve chain
    for (genvar g = 0; g < MAX_COUNT; g++) begin : g_cell
        tdpl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (clear),
            .i_slot  (slots[g]),
            .o_slot  (slots[g+1]),
            .o_emit  (emits[g])
        );
    end

    // At most one cell captures per cycle: merge by OR
    always_comb begin
        found = '0;
        for (int k = 0; k < MAX_COUNT; k++) begin
            if (emits[k].valid) begin
                found.valid = 1'b1;
                found.value = found.value | emits[k].value;
            end
        end
    end

    assign is_last = (r_have + COUNT_W'(1)) == r_want;
    assign clear   = (r_state == ST_RUN) && found.valid && is_last;

    // Sequencer and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == ST_RUN) && found.valid;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (clear) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value <= found.value[PRIME_W-1:0] & VALUE_MASK;
        r_last  <= is_last;
        if (accept) begin
            r_want <= n_want;
            r_have <= '0;
            r_cand <= CAND_W'(2);
        end else if (r_state == ST_RUN) begin
            r_cand <= r_cand + CAND_W'(1);
            if (found.valid) begin
                r_have <= r_have + COUNT_W'(1);
            end
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;
    assign o_prime_value = r_value;
    assign o_last_in_run = r_last;

endmodule

@@ bench/trial_division_prime_list_checker.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_list_checker
// Watches the request and result ports of the prime list generator. For each
// accepted request it works out the run of primes that must follow, then
// compares every strobed result word against the oldest one still owed.
// ----------------------------------------------------------------------------
module trial_division_prime_list_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [tdpl_pkg::COUNT_W-1:0] i_prime_count,
    input  logic                         i_strobe,
    input  logic [tdpl_pkg::PRIME_W-1:0] i_prime_value,
    input  logic                         i_last_in_run,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tdpl_pkg::*;

    // One owed result word: the prime and its end-of-run flag
    typedef struct packed {
        logic [PRIME_W-1:0] value;
        logic               last;
    } t_prime_word;

    t_prime_word primes_owed[$];
    int          mismatches = 0;

    // Plain trial division: no divisor in [2, cand-1]
    function automatic bit has_no_divisor(input int cand);
        for (int d = 2; d < cand; d++) begin
            if (cand % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue the first N primes for one request; count clamps to [1, MAX_COUNT]
    function automatic void owe_first_primes(input logic [COUNT_W-1:0] requested);
        int          want;
        int          found;
        int          cand;
        t_prime_word w;
        want = int'(requested);
        if (want > MAX_COUNT) want = MAX_COUNT;
        if (want < 1) want = 1;
        w.value = PRIME_W'(2) & VALUE_MASK;
        w.last  = (want == 1);
        primes_owed = {primes_owed, w};
        found = 1;
        cand  = 3;
        while (found < want) begin
            if (has_no_divisor(cand)) begin
                found++;
                w.value = PRIME_W'(cand) & VALUE_MASK;
                w.last  = (found == want);
                primes_owed = {primes_owed, w};
            end
            cand++;
        end
    endfunction

    // Sample both channels at the edge; request first, then the result word
    always @(posedge i_clk) begin
        t_prime_word due;
        if (i_rst_n) begin
            if (i_start && !i_busy) owe_first_primes(i_prime_count);
            if (i_strobe) begin
                if (primes_owed.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, actual value %0d last %0b",
                             $time, i_prime_value, i_last_in_run);
                end else begin
                    due = primes_owed.pop_front();
                    if (i_prime_value !== due.value) begin
                        mismatches++;
                        $display("%0t: prime_value mismatch: expected %0d, actual %0d",
                                 $time, due.value, i_prime_value);
                    end
                    if (i_last_in_run !== due.last) begin
                        mismatches++;
                        $display("%0t: last_in_run mismatch (value %0d): expected %0b, actual %0b",
                                 $time, due.value, due.last, i_last_in_run);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= primes_owed.size();
    end

endmodule

@@ bench/trial_division_prime_list_test.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_list_test
// Drives prime-count requests into the generator: a directed set over the
// count extremes and clamping, then random requests under several sender
// idle rates, with drains between phases. The checker module does the
// prediction and comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
module trial_division_prime_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdpl_pkg::*;

    localparam int RANDOM_REQUESTS = 125;
    localparam int SETTLE_CYCLES   = 400;    // longer than one full 64-prime run
    localparam int STALL_LIMIT     = 20000;  // cycles with no word moving

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [COUNT_W-1:0] i_prime_count;
    logic               o_strobe;
    logic [PRIME_W-1:0] o_prime_value;
    logic               o_last_in_run;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles = 0;

    trial_division_prime_list DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_prime_count (i_prime_count),
        .o_strobe      (o_strobe),
        .o_prime_value (o_prime_value),
        .o_last_in_run (o_last_in_run)
    );

    trial_division_prime_list_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_prime_count (i_prime_count),
        .i_strobe      (o_strobe),
        .i_prime_value (o_prime_value),
        .i_last_in_run (o_last_in_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: give up when neither a request nor a result word moves
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request, optionally idling first; returns at the accepting edge.
    // start stays high on return so back-to-back requests never toggle it.
    task automatic issue_request(input int count, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_prime_count <= COUNT_W'(count);
        do @(posedge i_clk); while (busy);
    endtask

    // Hold off new requests until every owed word has arrived
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly short runs, some up to the bound, a few past it (clamped)
    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(0, 16);
        if (roll < 90) return $urandom_range(17, 64);
        return $urandom_range(65, 127);
    endfunction

    initial begin
        int directed_counts[$] = '{0, 1, 2, 3, 4, 5, 63, 64, 65, 127, 7, 31, 10, 42, 100};
        int idle_by_phase[4]   = '{0, 63, 0, 23};
        int phase;
        int prev_phase;

        start         <= 1'b0;
        i_prime_count <= '0;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero and one, small counts, bound, above bound, all-ones
        foreach (directed_counts[k]) issue_request(directed_counts[k], 0);
        drain_results();

        // Random requests across idle phases, draining at each phase change
        prev_phase = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            phase = n * 4 / RANDOM_REQUESTS;
            if (phase != prev_phase) drain_results();
            prev_phase = phase;
            issue_request(pick_count(), idle_by_phase[phase]);
        end

        // Wrap up: let all owed words come, then watch for stray ones
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
